// File: sv/bh2d_pkg.sv
package bh2d_pkg;

	localparam int MAX_EDGES_X = 16;
	localparam int MAX_EDGES_Y = 16;
	localparam int VALUE_BITS  = 32;
	localparam int COUNT_BITS  = 32;

	localparam int BINS_X     = MAX_EDGES_X - 1;
	localparam int BINS_Y     = MAX_EDGES_Y - 1;
	localparam int BIN_DEPTH  = BINS_X * BINS_Y;
	localparam int ADDR_BITS  = $clog2(BIN_DEPTH);
	localparam int BIN_BITS   = 4;
	localparam int SLOT_BITS  = 4;
	localparam int CFG_BITS   = 5;
	localparam int CFG_IDX_BITS = 2;

	localparam logic [CFG_IDX_BITS-1:0] REG_EDGE_COUNT_X = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_EDGE_COUNT_Y = 2'd1;

	localparam logic [CFG_BITS-1:0] EDGE_COUNT_MIN = 5'd2;

	typedef enum logic [1:0] {
		OP_SAMPLE  = 2'd0,
		OP_WRITE_X = 2'd1,
		OP_WRITE_Y = 2'd2,
		OP_READ    = 2'd3
	} op_t;

	typedef struct packed {
		op_t                           operation;
		logic signed [VALUE_BITS-1:0]  x_value;
		logic signed [VALUE_BITS-1:0]  y_value;
		logic [SLOT_BITS-1:0]          edge_slot;
		logic signed [VALUE_BITS-1:0]  edge_value;
		logic [BIN_BITS-1:0]           read_bin_x;
		logic [BIN_BITS-1:0]           read_bin_y;
	} in_item_t;

	typedef struct packed {
		logic [BIN_BITS-1:0]   found_bin_x;
		logic [BIN_BITS-1:0]   found_bin_y;
		logic [COUNT_BITS-1:0] bin_count;
		logic                  order_error;
	} out_item_t;

	typedef struct packed {
		logic load;
		logic bin;
		logic read;
		logic update;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} status_t;

endpackage

// File: sv/binned_histogram_2d.sv
// Two-dimensional histogram over signed sample pairs with loadable bin edges. Each
// item is one operation: a sample pair (binned on both axes by parallel edge
// comparators, its bin count incremented and returned), an x or y edge write
// (refused with order_error when not above the previous edge), or a bin count read.
// Every item yields exactly one result. The block takes no new item until the last one
// has passed bin search, count memory read and update, set by the
// registered read-modify-write on the count memory; a stalled result holds back the update
// only once a second result is ready behind it. Counts start at zero
// after reset with no clearing pass. Write edges in ascending slot order before
// sending samples, and write the edge count registers only while the block is idle.
module binned_histogram_2d (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	output logic                              item_stall,
	input  bh2d_pkg::in_item_t                item,
	output logic                              result_valid,
	input  logic                              result_stall,
	output bh2d_pkg::out_item_t               result,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [bh2d_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [bh2d_pkg::CFG_BITS-1:0]     cfg_data
);
	import bh2d_pkg::*;

	cmd_t    cmd;
	status_t status;

	assign cfg_ready = 1'b1;

	bh2d_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.cmd        (cmd),
		.status     (status)
	);

	bh2d_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cmd          (cmd),
		.status       (status),
		.cfg_write    (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

// File: sv/bh2d_ram.sv
module bh2d_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 225
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: sv/bh2d_ctrl.sv
module bh2d_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	output bh2d_pkg::cmd_t    cmd,
	input  bh2d_pkg::status_t status
);
	import bh2d_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_BIN    = 4'b0010,
		ST_READ   = 4'b0100,
		ST_UPDATE = 4'b1000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_BIN;
				end
			end
			ST_BIN: begin
				cmd.bin = 1'b1;
				state_d = ST_READ;
			end
			ST_READ: begin
				cmd.read = 1'b1;
				state_d  = ST_UPDATE;
			end
			ST_UPDATE: begin
				// hold until the result register can take the item
				if (status.out_free) begin
					cmd.update = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign item_stall = (state_q != ST_IDLE);

endmodule

// File: sv/bh2d_dpath.sv
module bh2d_dpath (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  bh2d_pkg::in_item_t                     item,
	input  bh2d_pkg::cmd_t                         cmd,
	output bh2d_pkg::status_t                      status,
	input  logic                                   cfg_write,
	input  logic [bh2d_pkg::CFG_IDX_BITS-1:0]      cfg_index,
	input  logic [bh2d_pkg::CFG_BITS-1:0]          cfg_data,
	output logic                                   result_valid,
	input  logic                                   result_stall,
	output bh2d_pkg::out_item_t                    result
);
	import bh2d_pkg::*;

	localparam logic signed [VALUE_BITS-1:0] VALUE_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
	localparam logic [CFG_BITS-1:0] MAX_X_C = CFG_BITS'(MAX_EDGES_X);
	localparam logic [CFG_BITS-1:0] MAX_Y_C = CFG_BITS'(MAX_EDGES_Y);

	logic [CFG_BITS-1:0] edge_count_x_q, edge_count_y_q;
	logic [CFG_BITS-1:0] nx, ny;

	in_item_t in_q;
	logic signed [VALUE_BITS-1:0] x_edges_q [MAX_EDGES_X];
	logic signed [VALUE_BITS-1:0] y_edges_q [MAX_EDGES_Y];

	logic [BIN_BITS-1:0] bx, by;
	logic [BIN_BITS-1:0] bx_q, by_q;
	logic                err_q, range_ok_q;
	logic [ADDR_BITS-1:0] addr, addr_q;
	logic [BIN_DEPTH-1:0] valid_q;

	logic signed [VALUE_BITS-1:0] prev_x, prev_y, prev;
	logic order_err, read_ok;

	logic [COUNT_BITS-1:0] rd_data, cur_count, new_count;
	logic                  ram_wr;

	out_item_t result_q, result_d;
	logic      result_valid_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_count_x_q <= EDGE_COUNT_MIN;
			edge_count_y_q <= EDGE_COUNT_MIN;
		end else if (cfg_write) begin
			if (cfg_index == REG_EDGE_COUNT_X) begin
				edge_count_x_q <= cfg_data;
			end
			if (cfg_index == REG_EDGE_COUNT_Y) begin
				edge_count_y_q <= cfg_data;
			end
		end
	end

	always_comb begin
		nx = edge_count_x_q;
		if (edge_count_x_q < EDGE_COUNT_MIN) nx = EDGE_COUNT_MIN;
		else if (edge_count_x_q > MAX_X_C) nx = MAX_X_C;
		ny = edge_count_y_q;
		if (edge_count_y_q < EDGE_COUNT_MIN) ny = EDGE_COUNT_MIN;
		else if (edge_count_y_q > MAX_Y_C) ny = MAX_Y_C;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			in_q <= item;
		end
	end

	// parallel edge compare; walk down so the smallest matching edge wins
	always_comb begin
		bx = '0;
		for (int i = MAX_EDGES_X - 1; i >= 1; i--) begin
			if (CFG_BITS'(i) < nx && in_q.x_value <= x_edges_q[i]) begin
				bx = BIN_BITS'(i - 1);
			end
		end
		by = '0;
		for (int j = MAX_EDGES_Y - 1; j >= 1; j--) begin
			if (CFG_BITS'(j) < ny && in_q.y_value <= y_edges_q[j]) begin
				by = BIN_BITS'(j - 1);
			end
		end
	end

	always_comb begin
		prev_x = (in_q.edge_slot == '0) ? VALUE_MIN : x_edges_q[in_q.edge_slot - 1'b1];
		prev_y = (in_q.edge_slot == '0) ? VALUE_MIN : y_edges_q[in_q.edge_slot - 1'b1];
		prev   = (in_q.operation == OP_WRITE_X) ? prev_x : prev_y;
		order_err = (in_q.edge_value <= prev);
		read_ok = ({1'b0, in_q.read_bin_x} < nx - 1'b1) &&
		          ({1'b0, in_q.read_bin_y} < ny - 1'b1);
	end

	always_ff @(posedge clk) begin
		if (cmd.bin) begin
			err_q      <= 1'b0;
			range_ok_q <= 1'b0;
			bx_q       <= '0;
			by_q       <= '0;
			case (in_q.operation)
				OP_SAMPLE: begin
					bx_q <= bx;
					by_q <= by;
				end
				OP_WRITE_X: begin
					err_q <= order_err;
					if (!order_err) x_edges_q[in_q.edge_slot] <= in_q.edge_value;
				end
				OP_WRITE_Y: begin
					err_q <= order_err;
					if (!order_err) y_edges_q[in_q.edge_slot] <= in_q.edge_value;
				end
				OP_READ: begin
					range_ok_q <= read_ok;
					// out-of-range reads point at bin 0 and report zero
					if (read_ok) begin
						bx_q <= in_q.read_bin_x;
						by_q <= in_q.read_bin_y;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign addr = ADDR_BITS'(by_q) * ADDR_BITS'(BINS_X) + ADDR_BITS'(bx_q);

	always_ff @(posedge clk) begin
		if (cmd.read) begin
			addr_q <= addr;
		end
	end

	assign ram_wr = cmd.update && (in_q.operation == OP_SAMPLE);

	bh2d_ram #(
		.WIDTH(COUNT_BITS),
		.DEPTH(BIN_DEPTH)
	) u_counts (
		.clk     (clk),
		.wr_en   (ram_wr),
		.wr_addr (addr_q),
		.wr_data (new_count),
		.rd_en   (cmd.read),
		.rd_addr (addr),
		.rd_data (rd_data)
	);

	// a bin never written since reset reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ram_wr) begin
			valid_q[addr_q] <= 1'b1;
		end
	end

	assign cur_count = valid_q[addr_q] ? rd_data : '0;
	assign new_count = cur_count + 1'b1;

	always_comb begin
		result_d = '0;
		case (in_q.operation)
			OP_SAMPLE: begin
				result_d.found_bin_x = bx_q;
				result_d.found_bin_y = by_q;
				result_d.bin_count   = new_count;
			end
			OP_WRITE_X, OP_WRITE_Y: begin
				result_d.order_error = err_q;
			end
			OP_READ: begin
				result_d.bin_count = range_ok_q ? cur_count : '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			result_q <= result_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.update) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	assign status.out_free = !result_valid_q || !result_stall;
	assign result_valid    = result_valid_q;
	assign result          = result_q;

endmodule
